@@ sv/lz10_pkg.sv @@
// Shared constants and control/status types for the LZ10 window decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package lz10_pkg;

   localparam int WINDOW_DEPTH = 4096;
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
   localparam int DIST_W       = WIN_AW + 1;
   localparam int LIMIT_W      = 24;
   localparam int LEN_W        = 5;
   localparam int CSR_AW       = 3;

   localparam logic [LEN_W-1:0] LEN_BIAS   = 5'd3;
   localparam logic [3:0]       TOKENS_PER_FLAG = 4'd8;

   // Register indexes, taken from the word address of the CSR port.
   localparam logic REG_OUTPUT_LIMIT = 1'b0;

   typedef struct packed {
      logic accept;      // input beat taken this cycle
      logic copy_emit;   // a match byte is pushed to the output this cycle
   } lz10_cmd_type;

   typedef struct packed {
      logic start_copy;  // the beat on the input would start a match copy
      logic out_free;    // output register can take a byte this cycle
      logic count_one;   // the match byte being emitted is its last one
      logic rem_zero;    // output limit reached
   } lz10_status_type;

endpackage

@@ sv/lz10_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the decoder history window.
module lz10_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/lz10_ctrl.sv @@
// Controller state machine: input handshake and the read/emit sequence of a match copy.
// Depends on lz10_pkg for the command and status types.
module lz10_ctrl import lz10_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            restart,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  lz10_status_type status,
   output lz10_cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   assign req_tready    = (state_ff == S_IDLE) && status.out_free;
   assign cmd.accept    = req_tready && req_tvalid;
   assign cmd.copy_emit = (state_ff == S_EMIT) && status.out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.accept && status.start_copy) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               state_in = status.count_one ? S_IDLE : S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/lz10_dpath.sv @@
// Datapath: token parsing, match length/distance, write pointer, history window
// and the output register. Depends on lz10_pkg and lz10_ram.
module lz10_dpath import lz10_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               restart,
   input  logic [LIMIT_W-1:0] limit,
   input  logic [7:0]         stream_byte,
   input  lz10_cmd_type       cmd,
   output lz10_status_type    status,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic [7:0]         out_byte,
   output logic               last_of_run,
   output logic               stream_done
);

   logic [WIN_AW-1:0]  wp_ff, wp_in;
   logic [DIST_W-1:0]  fill_ff, fill_in;
   logic [LIMIT_W-1:0] rem_ff, rem_in;
   logic [7:0]         flags_ff, flags_in;
   logic [3:0]         tokens_ff, tokens_in;
   logic               phase_ff, phase_in;
   logic [7:0]         first_ff, first_in;
   logic [LEN_W-1:0]   count_ff, count_in;
   logic [DIST_W-1:0]  dist_ff, dist_in;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff, out_byte_in;
   logic               out_last_ff, out_last_in;
   logic               out_done_ff, out_done_in;

   logic               rem_zero;
   logic               literal;
   logic               emit;
   logic [7:0]         emit_byte;
   logic [LEN_W-1:0]   match_len;
   logic [WIN_AW-1:0]  rd_addr;
   logic [7:0]         rd_data;
   logic               hit;

   assign rem_zero = (rem_ff == '0);
   assign literal  = !rem_zero && !phase_ff && (tokens_ff != '0) && !flags_ff[7];
   assign emit     = (cmd.accept && literal) || cmd.copy_emit;

   assign status.start_copy = !rem_zero && phase_ff;
   assign status.out_free   = !out_valid_ff || rsp_tready;
   assign status.count_one  = (count_ff == LEN_W'(1));
   assign status.rem_zero   = rem_zero;

   // Entries at a distance beyond the fill count were never written since restart and read as zero.
   assign hit       = (dist_ff <= fill_ff);
   assign rd_addr   = wp_ff - dist_ff[WIN_AW-1:0];
   assign emit_byte = cmd.copy_emit ? (hit ? rd_data : 8'd0) : stream_byte;

   always_comb begin
      match_len = {1'b0, first_ff[7:4]} + LEN_BIAS;
      if (rem_ff < LIMIT_W'(match_len)) begin
         match_len = rem_ff[LEN_W-1:0];
      end
   end

   always_comb begin
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      rem_in    = rem_ff;
      flags_in  = flags_ff;
      tokens_in = tokens_ff;
      phase_in  = phase_ff;
      first_in  = first_ff;
      count_in  = count_ff;
      dist_in   = dist_ff;

      if (cmd.accept && !rem_zero) begin
         if (phase_ff) begin
            count_in  = match_len;
            dist_in   = {1'b0, first_ff[3:0], stream_byte} + DIST_W'(1);
            phase_in  = 1'b0;
            flags_in  = {flags_ff[6:0], 1'b0};
            tokens_in = tokens_ff - 4'd1;
         end else if (tokens_ff == '0) begin
            flags_in  = stream_byte;
            tokens_in = TOKENS_PER_FLAG;
         end else if (flags_ff[7]) begin
            first_in  = stream_byte;
            phase_in  = 1'b1;
         end else begin
            flags_in  = {flags_ff[6:0], 1'b0};
            tokens_in = tokens_ff - 4'd1;
         end
      end

      if (emit) begin
         wp_in  = wp_ff + WIN_AW'(1);
         rem_in = rem_ff - LIMIT_W'(1);
         if (fill_ff != DIST_W'(WINDOW_DEPTH)) begin
            fill_in = fill_ff + DIST_W'(1);
         end
      end
      if (cmd.copy_emit) begin
         count_in = count_ff - LEN_W'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_done_in  = out_done_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = cmd.copy_emit ? status.count_one : 1'b1;
         out_done_in  = out_last_in && (rem_ff == LIMIT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_done_ff <= out_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         fill_ff   <= '0;
         rem_ff    <= '0;
         flags_ff  <= '0;
         tokens_ff <= '0;
         phase_ff  <= 1'b0;
         first_ff  <= '0;
         count_ff  <= '0;
         dist_ff   <= DIST_W'(1);
      end else if (restart) begin
         wp_ff     <= '0;
         fill_ff   <= '0;
         rem_ff    <= limit;
         flags_ff  <= '0;
         tokens_ff <= '0;
         phase_ff  <= 1'b0;
         first_ff  <= '0;
         count_ff  <= '0;
         dist_ff   <= DIST_W'(1);
      end else begin
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         rem_ff    <= rem_in;
         flags_ff  <= flags_in;
         tokens_ff <= tokens_in;
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         count_ff  <= count_in;
         dist_ff   <= dist_in;
      end
   end

   lz10_ram #(
      .WIDTH(8),
      .DEPTH(WINDOW_DEPTH)
   ) u_window (
      .clock  (clock),
      .wr_en  (emit),
      .wr_addr(wp_ff),
      .wr_data(emit_byte),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_tvalid  = out_valid_ff;
   assign out_byte    = out_byte_ff;
   assign last_of_run = out_last_ff;
   assign stream_done = out_done_ff;

endmodule

@@ sv/lz10_window_decoder.sv @@
// LZ10 window decoder top level: CSR port, controller and datapath.
// Depends on lz10_pkg, lz10_ctrl, lz10_dpath and lz10_ram.
//
// Usage: write output_limit (CSR byte address 0) with the decompressed size,
// which restarts the decoder, then stream the compressed bytes that follow
// the header in on req_*, one byte per beat. Results leave on rsp_* one byte
// per beat; rsp_tlast marks the last byte caused by an input beat and
// rsp_tuser marks the byte that completes the output limit.
// A flag byte or the first byte of a match gives no output. A literal
// appears on rsp_* the cycle after it is taken. A match copies each byte
// by a window RAM read, then an emit that waits while the output stalls,
// for up to 18 bytes per match; no input is taken while a copy runs.
// Window entries not yet written since restart read as zero; this is tracked
// by a fill count, so restart costs no clearing pass.
// After reset the limit is zero and every input beat is taken and dropped.
// When the receiver stalls, the output register holds its byte and input is
// taken only when that register can be refilled in the same cycle.
module lz10_window_decoder import lz10_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] stream_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast,   // last_of_run
   output logic              rsp_tuser,   // [0] stream_done
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic               restart;
   lz10_cmd_type       cmd;
   lz10_status_type    status;

   assign csr_pready = 1'b1;
   assign restart    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == REG_OUTPUT_LIMIT);
   assign limit_in   = restart ? csr_pwdata[LIMIT_W-1:0] : limit_ff;
   assign csr_prdata = (csr_paddr[2] == REG_OUTPUT_LIMIT) ?
                       {{(32-LIMIT_W){1'b0}}, limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else begin
         limit_ff <= limit_in;
      end
   end

   lz10_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   lz10_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .limit      (limit_in),
      .stream_byte(req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .out_byte   (rsp_tdata),
      .last_of_run(rsp_tlast),
      .stream_done(rsp_tuser)
   );

   // No input beat is taken while a match copy is emitting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.copy_emit |-> !req_tready)
      else $error("input taken during a match copy");

   // A completed limit is always the last byte of its input beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("stream_done without last_of_run");

   // Once the final byte is out and no restart follows, the limit stays reached.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser && !restart |-> status.rem_zero)
      else $error("bytes still owed after stream_done");

   // Writing the limit loads it into the remaining count.
   assert property (@(posedge clock) disable iff (reset)
      restart |=> (status.rem_zero == ($past(csr_pwdata[LIMIT_W-1:0]) == '0)))
      else $error("restart did not load the output limit");

endmodule
